/* rtl/mat_pkg.sv */
package mat_pkg;

  // Fixed-point format and counter width.
  localparam int FRAC_BITS   = 16;
  localparam int COUNT_WIDTH = 32;

  // Logarithm unit: 28 fraction bits, one squaring per stage after normalising.
  localparam int LOG_FRAC   = 28;
  localparam int LOG_STAGES = LOG_FRAC + 1;
  localparam int L2_W       = 5 + LOG_FRAC;
  localparam int LD_W       = L2_W + 1;

  // Natural log conversion: ln2 as a Q0.30 constant, rounded shift to FRAC_BITS.
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam int          LN_SH   = LOG_FRAC + 30 - FRAC_BITS;
  localparam logic [63:0] LN_HALF = 64'd1 << (LN_SH - 1);
  localparam int          LN_W    = FRAC_BITS + 7;
  localparam int          LVN_W   = LN_W + 17;

  // Saturating multiply-and-shift of the energy terms.
  localparam int          SAT_W     = 47;
  localparam logic [79:0] SAT_LIMIT = 80'd1 << 46;
  localparam int          DELTA_W   = 50;

  // Stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 248;
  localparam int OUT_TDATA_W = 72;

  // Main pipeline depth, not counting the output register.
  localparam int NST = 38;

  typedef enum logic [2:0] {
    ACT_NVT      = 3'd0,
    ACT_NVT_BIAS = 3'd1,
    ACT_NPT      = 3'd2,
    ACT_NPT_BIAS = 3'd3,
    ACT_CLEAR    = 3'd4
  } action_t;

  typedef enum logic {
    REG_BETA     = 1'b0,
    REG_PRESSURE = 1'b1
  } reg_idx_t;

  // Everything an item carries down the pipeline; each stage fills in its part.
  typedef struct packed {
    logic [2:0]                action;
    logic [31:0]               energy_new;
    logic [31:0]               energy_old;
    logic [31:0]               bias_new;
    logic [31:0]               bias_old;
    logic [15:0]               molecule_count;
    logic [31:0]               volume_new;
    logic [31:0]               volume_old;
    logic [31:0]               random_fraction;
    logic                      rnd_zero;
    logic signed [32:0]        de;
    logic signed [32:0]        dv;
    logic                      dv_neg;
    logic [32:0]               dv_mag;
    logic [63:0]               pdv_lo;
    logic [31:0]               pdv_hi;
    logic [79:0]               pdv_sum;
    logic [SAT_W-1:0]          pdv_mag;
    logic signed [47:0]        e;
    logic                      e_neg;
    logic [47:0]               e_mag;
    logic [63:0]               bt_lo;
    logic [47:0]               bt_hi;
    logic [79:0]               bt_sum;
    logic [SAT_W-1:0]          bt_mag;
    logic signed [47:0]        dbeta;
    logic signed [LD_W-1:0]    lv_d;
    logic signed [LD_W-1:0]    lb_d;
    logic signed [LD_W-1:0]    lr_d;
    logic                      lv_neg;
    logic                      lb_neg;
    logic                      lr_neg;
    logic [LD_W-1:0]           lv_mag;
    logic [LD_W-1:0]           lb_mag;
    logic [LD_W-1:0]           lr_mag;
    logic [63:0]               lv_prod;
    logic [63:0]               lb_prod;
    logic [63:0]               lr_prod;
    logic [LN_W-2:0]           lv_lnm;
    logic [LN_W-2:0]           lb_lnm;
    logic [LN_W-2:0]           lr_lnm;
    logic signed [LN_W-1:0]    ln_v;
    logic signed [LN_W-1:0]    ln_b;
    logic signed [LN_W-1:0]    ln_r;
    logic signed [LVN_W-1:0]   lvn;
    logic signed [LN_W-1:0]    lb_term;
    logic signed [DELTA_W-1:0] delta;
    logic                      acc;
  } pl_t;

endpackage

/* rtl/metropolis_acceptance_test_top.sv */
// Metropolis-Hastings acceptance test for NVT and NPT moves in Q16.16 log
// domain. The block takes one item per clock unless the pipeline is full
// behind a stalled output, and returns results in the order taken: each
// item is registered in the first of 38 pipeline stages as it is taken,
// then passes the other 37 stages and the output register. The depth is
// set by the five logarithm units, each of which normalises and then
// squares once per stage for 28 stages; the energy and pressure products
// run alongside them. Valid bits travel with each stage, so idle slots
// close up behind a stalled output and input items keep being taken until
// the pipeline is full. Configuration registers are read by items in
// flight, so they should only be written while the pipeline is empty.
module metropolis_acceptance_test_top import mat_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // action, energy_new, energy_old, bias_new, bias_old, molecule_count,
  // volume_new, volume_old, random_fraction (lowest bit first)
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // accepted, accept_total, reject_total (lowest bit first)
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [31:0]            cfg_wdata
);

  logic [31:0] beta_r;
  logic [31:0] pressure_r;

  pl_t         pipe_r   [NST];
  pl_t         pipe_nxt [NST];
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  logic [COUNT_WIDTH-1:0] acc_cnt_r, acc_cnt_nxt;
  logic [COUNT_WIDTH-1:0] rej_cnt_r, rej_cnt_nxt;
  logic                   out_valid_r;
  logic                   out_acc_r;
  logic [31:0]            out_acc_tot_r;
  logic [31:0]            out_rej_tot_r;

  logic [L2_W-1:0] l2_vn, l2_vo, l2_bn, l2_bo, l2_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r     <= 32'd110049;
      pressure_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BETA:     beta_r     <= cfg_wdata;
        REG_PRESSURE: pressure_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // A stage may load when it or some stage after it has room.
  assign rdy[NST] = !out_valid_r || out_tready;
  for (genvar i = 0; i < NST; i++) begin : g_rdy
    assign rdy[i] = rdy[NST] || !(&v_r[NST-1:i]);
  end
  assign in_tready = rdy[0];

  // Logarithm units; unit stage j sits alongside pipeline stage j+1.
  mat_log2 u_log_vn (.clk(clk), .en(rdy[LOG_STAGES:1]), .x(pipe_r[0].volume_new),
                     .l2(l2_vn));
  mat_log2 u_log_vo (.clk(clk), .en(rdy[LOG_STAGES:1]), .x(pipe_r[0].volume_old),
                     .l2(l2_vo));
  mat_log2 u_log_bn (.clk(clk), .en(rdy[LOG_STAGES:1]), .x(pipe_r[0].bias_new),
                     .l2(l2_bn));
  mat_log2 u_log_bo (.clk(clk), .en(rdy[LOG_STAGES:1]), .x(pipe_r[0].bias_old),
                     .l2(l2_bo));
  mat_log2 u_log_r  (.clk(clk), .en(rdy[LOG_STAGES:1]), .x(pipe_r[0].random_fraction),
                     .l2(l2_r));

  // Stage logic: each stage copies its predecessor and adds its own work.
  always_comb begin
    logic        npt_1, npt_5, npt_34, bias_34;
    logic [79:0] sh_pdv, sh_bt;
    logic [DELTA_W-1:0] a0, a1, a2;

    pipe_nxt[0] = pipe_r[0];
    pipe_nxt[0].action          = in_tdata[2:0];
    pipe_nxt[0].energy_new      = in_tdata[34:3];
    pipe_nxt[0].energy_old      = in_tdata[66:35];
    pipe_nxt[0].bias_new        = in_tdata[98:67];
    pipe_nxt[0].bias_old        = in_tdata[130:99];
    pipe_nxt[0].molecule_count  = in_tdata[146:131];
    pipe_nxt[0].volume_new      = in_tdata[178:147];
    pipe_nxt[0].volume_old      = in_tdata[210:179];
    pipe_nxt[0].random_fraction = in_tdata[242:211];
    for (int i = 1; i < NST; i++) begin
      pipe_nxt[i] = pipe_r[i-1];
    end

    // Energy and volume differences.
    pipe_nxt[1].de = $signed({pipe_r[0].energy_new[31], pipe_r[0].energy_new})
                   - $signed({pipe_r[0].energy_old[31], pipe_r[0].energy_old});
    pipe_nxt[1].dv = $signed({1'b0, pipe_r[0].volume_new})
                   - $signed({1'b0, pipe_r[0].volume_old});
    pipe_nxt[1].rnd_zero = (pipe_r[0].random_fraction == 32'd0);

    pipe_nxt[2].dv_neg = pipe_r[1].dv[32];
    pipe_nxt[2].dv_mag = pipe_r[1].dv[32] ? 33'(-pipe_r[1].dv) : 33'(pipe_r[1].dv);

    // Pressure times volume change, split into low and high partial products.
    pipe_nxt[3].pdv_lo = 64'(pipe_r[2].dv_mag[31:0]) * 64'(pressure_r);
    pipe_nxt[3].pdv_hi = pipe_r[2].dv_mag[32] ? pressure_r : 32'd0;

    pipe_nxt[4].pdv_sum = {16'd0, pipe_r[3].pdv_hi, 32'd0} + {16'd0, pipe_r[3].pdv_lo};

    sh_pdv = pipe_r[4].pdv_sum >> FRAC_BITS;
    pipe_nxt[5].pdv_mag = (sh_pdv > SAT_LIMIT) ? SAT_LIMIT[SAT_W-1:0] : sh_pdv[SAT_W-1:0];

    // Add the pressure term in NPT modes.
    npt_5 = (pipe_r[5].action == ACT_NPT) || (pipe_r[5].action == ACT_NPT_BIAS);
    if (!npt_5) begin
      pipe_nxt[6].e = 48'(pipe_r[5].de);
    end else if (pipe_r[5].dv_neg) begin
      pipe_nxt[6].e = 48'(pipe_r[5].de) - $signed({1'b0, pipe_r[5].pdv_mag});
    end else begin
      pipe_nxt[6].e = 48'(pipe_r[5].de) + $signed({1'b0, pipe_r[5].pdv_mag});
    end

    pipe_nxt[7].e_neg = pipe_r[6].e[47];
    pipe_nxt[7].e_mag = pipe_r[6].e[47] ? 48'(-pipe_r[6].e) : 48'(pipe_r[6].e);

    // Inverse temperature times energy term.
    pipe_nxt[8].bt_lo = 64'(pipe_r[7].e_mag[31:0]) * 64'(beta_r);
    pipe_nxt[8].bt_hi = 48'(pipe_r[7].e_mag[47:32]) * 48'(beta_r);

    pipe_nxt[9].bt_sum = {pipe_r[8].bt_hi, 32'd0} + {16'd0, pipe_r[8].bt_lo};

    sh_bt = pipe_r[9].bt_sum >> FRAC_BITS;
    pipe_nxt[10].bt_mag = (sh_bt > SAT_LIMIT) ? SAT_LIMIT[SAT_W-1:0] : sh_bt[SAT_W-1:0];

    // The energy term enters delta with its sign inverted.
    pipe_nxt[11].dbeta = pipe_r[10].e_neg ? $signed({1'b0, pipe_r[10].bt_mag})
                                          : -$signed({1'b0, pipe_r[10].bt_mag});

    // Logarithm differences in Q.28.
    pipe_nxt[30].lv_d = $signed({1'b0, l2_vn}) - $signed({1'b0, l2_vo});
    pipe_nxt[30].lb_d = $signed({1'b0, l2_bn}) - $signed({1'b0, l2_bo});
    pipe_nxt[30].lr_d = $signed({1'b0, l2_r}) - $signed(LD_W'(32) << LOG_FRAC);

    pipe_nxt[31].lv_neg = pipe_r[30].lv_d[LD_W-1];
    pipe_nxt[31].lb_neg = pipe_r[30].lb_d[LD_W-1];
    pipe_nxt[31].lr_neg = pipe_r[30].lr_d[LD_W-1];
    pipe_nxt[31].lv_mag = pipe_r[30].lv_d[LD_W-1] ? LD_W'(-pipe_r[30].lv_d)
                                                  : LD_W'(pipe_r[30].lv_d);
    pipe_nxt[31].lb_mag = pipe_r[30].lb_d[LD_W-1] ? LD_W'(-pipe_r[30].lb_d)
                                                  : LD_W'(pipe_r[30].lb_d);
    pipe_nxt[31].lr_mag = pipe_r[30].lr_d[LD_W-1] ? LD_W'(-pipe_r[30].lr_d)
                                                  : LD_W'(pipe_r[30].lr_d);

    // Scale by ln2, then round half away from zero on the magnitude.
    pipe_nxt[32].lv_prod = 64'(pipe_r[31].lv_mag) * 64'(LN2_Q30);
    pipe_nxt[32].lb_prod = 64'(pipe_r[31].lb_mag) * 64'(LN2_Q30);
    pipe_nxt[32].lr_prod = 64'(pipe_r[31].lr_mag) * 64'(LN2_Q30);

    pipe_nxt[33].lv_lnm = (LN_W-1)'((pipe_r[32].lv_prod + LN_HALF) >> LN_SH);
    pipe_nxt[33].lb_lnm = (LN_W-1)'((pipe_r[32].lb_prod + LN_HALF) >> LN_SH);
    pipe_nxt[33].lr_lnm = (LN_W-1)'((pipe_r[32].lr_prod + LN_HALF) >> LN_SH);

    pipe_nxt[34].ln_v = pipe_r[33].lv_neg ? -$signed({1'b0, pipe_r[33].lv_lnm})
                                          : $signed({1'b0, pipe_r[33].lv_lnm});
    pipe_nxt[34].ln_b = pipe_r[33].lb_neg ? -$signed({1'b0, pipe_r[33].lb_lnm})
                                          : $signed({1'b0, pipe_r[33].lb_lnm});
    pipe_nxt[34].ln_r = pipe_r[33].lr_neg ? -$signed({1'b0, pipe_r[33].lr_lnm})
                                          : $signed({1'b0, pipe_r[33].lr_lnm});

    // Volume term scaled by molecule count in NPT modes, bias term where the mode has it.
    npt_34  = (pipe_r[34].action == ACT_NPT) || (pipe_r[34].action == ACT_NPT_BIAS);
    bias_34 = (pipe_r[34].action == ACT_NVT_BIAS) || (pipe_r[34].action == ACT_NPT_BIAS);
    pipe_nxt[35].lvn = npt_34 ? LVN_W'(pipe_r[34].ln_v
                                       * $signed({1'b0, pipe_r[34].molecule_count}))
                              : '0;
    pipe_nxt[35].lb_term = bias_34 ? pipe_r[34].ln_b : '0;

    a0 = DELTA_W'(pipe_r[35].dbeta);
    a1 = DELTA_W'(pipe_r[35].lvn);
    a2 = DELTA_W'(pipe_r[35].lb_term);
    pipe_nxt[36].delta = $signed(a0 + a1 + a2);

    // Decision.
    npt_1 = 1'b0;
    if (pipe_r[36].action[2]) begin
      pipe_nxt[37].acc = 1'b0;
    end else if (pipe_r[36].action == ACT_NVT && pipe_r[36].de <= 0) begin
      pipe_nxt[37].acc = 1'b1;
    end else begin
      pipe_nxt[37].acc = (pipe_r[36].delta >= 0) || pipe_r[36].rnd_zero
                      || (pipe_r[36].delta > DELTA_W'(pipe_r[36].ln_r)) || npt_1;
    end
  end

  // Pipeline registers and their valid bits.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (rdy[i]) begin
        pipe_r[i] <= pipe_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Counter update for the item leaving the last stage.
  always_comb begin
    acc_cnt_nxt = acc_cnt_r;
    rej_cnt_nxt = rej_cnt_r;
    if (pipe_r[NST-1].action == ACT_CLEAR) begin
      acc_cnt_nxt = '0;
      rej_cnt_nxt = '0;
    end else if (!pipe_r[NST-1].action[2]) begin
      if (pipe_r[NST-1].acc) begin
        acc_cnt_nxt = acc_cnt_r + 1'b1;
      end else begin
        rej_cnt_nxt = rej_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r   <= '0;
      rej_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (rdy[NST]) begin
      out_valid_r <= v_r[NST-1];
      if (v_r[NST-1]) begin
        acc_cnt_r <= acc_cnt_nxt;
        rej_cnt_r <= rej_cnt_nxt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rdy[NST] && v_r[NST-1]) begin
      out_acc_r     <= pipe_r[NST-1].acc;
      out_acc_tot_r <= 32'(64'(acc_cnt_nxt));
      out_rej_tot_r <= 32'(64'(rej_cnt_nxt));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_rej_tot_r, out_acc_tot_r, out_acc_r};

endmodule

/* rtl/mat_log2.sv */
module mat_log2 import mat_pkg::*; (
  input  logic                  clk,
  input  logic [LOG_STAGES-1:0] en,
  input  logic [31:0]           x,
  output logic [L2_W-1:0]       l2
);

  logic [31:0]         z_r [LOG_STAGES];
  logic [4:0]          k_r [LOG_STAGES];
  logic [LOG_FRAC-1:0] f_r [LOG_STAGES];

  logic [31:0] x1;
  logic [4:0]  k0;
  logic [31:0] z0;

  // Find the top set bit (a zero input counts as one) and normalise to Q1.31.
  always_comb begin
    x1 = (x == 32'd0) ? 32'd1 : x;
    k0 = 5'd0;
    for (int b = 1; b < 32; b++) begin
      if (x1[b]) begin
        k0 = 5'(b);
      end
    end
    z0 = x1 << (5'd31 - k0);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      z_r[0] <= z0;
      k_r[0] <= k0;
      f_r[0] <= '0;
    end
  end

  // One squaring per stage yields one fraction bit, most significant first.
  for (genvar j = 1; j < LOG_STAGES; j++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] p;

    always_comb begin
      sq = 64'(z_r[j-1]) * 64'(z_r[j-1]);
      p  = sq[63:31];
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        k_r[j] <= k_r[j-1];
        if (p[32]) begin
          z_r[j] <= p[32:1];
          f_r[j] <= {f_r[j-1][LOG_FRAC-2:0], 1'b1};
        end else begin
          z_r[j] <= p[31:0];
          f_r[j] <= {f_r[j-1][LOG_FRAC-2:0], 1'b0};
        end
      end
    end
  end

  assign l2 = {k_r[LOG_STAGES-1], f_r[LOG_STAGES-1]};

endmodule

/* rtl/mat_checker.sv */
module mat_checker import mat_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  // With nothing waiting at the output, the pipeline always has room.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // An offered item is only held off while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind metropolis_acceptance_test_top mat_checker u_mat_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
